/* hw/rtl/emnr_pkg.sv */
`default_nettype none

package emnr_pkg;

    // Frame size limit used when the top level is not told otherwise.
    localparam int unsigned MAX_FRAME_BYTES_DEF = 2048;

    // Frame layout limits, in bytes.
    localparam int unsigned ETH_HDR_LEN = 14;
    localparam int unsigned IP_MIN_LEN  = 34;
    localparam int unsigned ARP_MIN_LEN = 42;

    localparam logic [15:0] TYPE_ARP   = 16'h0806;
    localparam logic [15:0] TYPE_IPV4  = 16'h0800;
    // High byte of the IPv4 fragment offset mask.
    localparam logic [7:0]  FRAG_HI_MASK = 8'h1F;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;
    // Source port 68 followed by destination port 67.
    localparam logic [31:0] DHCP_PORTS = {16'd68, 16'd67};
    localparam logic [7:0]  BCAST_BIT  = 8'h80;

    // Output queue geometry; the depth must be a power of two.
    localparam int unsigned OUTQ_DEPTH  = 16;
    localparam int unsigned OUTQ_AW     = 4;
    localparam int unsigned RELEASE_LEN = 6;

    // Number of output bytes one input byte pushes into the queue.
    localparam logic [2:0] PUSH_NONE  = 3'd0;
    localparam logic [2:0] PUSH_ONE   = 3'd1;
    localparam logic [2:0] PUSH_FIELD = 3'd6;

    // Register select, taken from bit 3 of the byte address.
    typedef enum logic {
        REG_STATION = 1'b0,
        REG_INNER   = 1'b1
    } reg_sel_t;

    // Output bytes produced by one input byte, in emission order (data[0] first).
    typedef struct packed {
        logic [2:0]      cnt;
        logic [5:0][7:0] data;
        logic            last;
        logic            changed;
    } push_t;

    // Byte i of a MAC address, byte 0 being the most significant.
    function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] i);
        logic [7:0] r;
        case (i)
            3'd0:    r = mac[47:40];
            3'd1:    r = mac[39:32];
            3'd2:    r = mac[31:24];
            3'd3:    r = mac[23:16];
            3'd4:    r = mac[15:8];
            3'd5:    r = mac[7:0];
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/emnr_rewrite.sv */
`default_nettype none

module emnr_rewrite #(
    parameter int unsigned MAX_FRAME_BYTES = emnr_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic                mode,
    input  logic [7:0]          data_byte,
    input  logic [10:0]         frame_len,
    input  logic [47:0]         station_mac,
    input  logic [47:0]         inner_mac,
    output emnr_pkg::push_t     push
);

    logic [10:0] pos_reg, pos_next;
    logic [10:0] len_reg, len_next;
    logic        dir_reg, dir_next;
    logic [15:0] etype_reg, etype_next;
    logic [6:0]  udp_reg, udp_next;
    logic        dhcp_reg, dhcp_next;
    logic [31:0] ports_reg, ports_next;
    logic        changed_reg, changed_next;
    logic [7:0]  hold_reg [0:4];

    logic        first;
    logic        last;
    logic        active;
    logic        arp;
    logic [7:0]  ob;
    logic        rel;
    logic        allow;
    logic [47:0] match_mac;
    logic [47:0] avoid_mac;
    logic [47:0] repl_mac;
    logic [47:0] cand;
    logic        swap;
    logic        hold_we;
    logic [2:0]  hold_idx;
    logic [5:0]  ihl;
    logic [11:0] hdr_end;
    logic [11:0] udp_end;
    logic [10:0] off;
    logic [6:0]  udp_val;

    assign cand = {hold_reg[0], hold_reg[1], hold_reg[2], hold_reg[3], hold_reg[4], data_byte};

    always_comb
    begin
        first        = (pos_reg == 11'd0);
        dir_next     = first ? mode : dir_reg;
        len_next     = first ? ((frame_len == 11'd0) ? 11'd1 : frame_len) : len_reg;
        etype_next   = first ? 16'h0000 : etype_reg;
        udp_next     = first ? 7'd0 : udp_reg;
        dhcp_next    = first ? 1'b0 : dhcp_reg;
        ports_next   = first ? 32'h0 : ports_reg;
        changed_next = first ? 1'b0 : changed_reg;

        last   = (({1'b0, pos_reg} + 12'd1) >= {1'b0, len_next});
        active = (len_next >= 11'(emnr_pkg::ETH_HDR_LEN)) &&
                 (32'(len_next) < MAX_FRAME_BYTES);

        ob        = data_byte;
        push      = '0;
        push.cnt  = emnr_pkg::PUSH_ONE;
        rel       = 1'b0;
        allow     = 1'b0;
        match_mac = inner_mac;
        avoid_mac = station_mac;
        repl_mac  = station_mac;
        hold_we   = 1'b0;
        hold_idx  = 3'd0;
        arp       = 1'b0;
        ihl       = {data_byte[3:0], 2'b00};
        hdr_end   = 12'(emnr_pkg::ETH_HDR_LEN) + {6'b0, ihl} + 12'd8;
        udp_val   = 7'(emnr_pkg::ETH_HDR_LEN) + {1'b0, ihl};
        udp_end   = 12'd0;
        off       = 11'd0;

        if (active)
        begin
            if (pos_reg == 11'd12)
            begin
                etype_next = {data_byte, 8'h00};
            end
            else if (pos_reg == 11'd13)
            begin
                etype_next = etype_next | {8'h00, data_byte};
            end
            arp = (etype_next == emnr_pkg::TYPE_ARP) &&
                  (len_next >= 11'(emnr_pkg::ARP_MIN_LEN));

            if (!dir_next)
            begin
                if (pos_reg >= 11'd6 && pos_reg <= 11'd11)
                begin
                    // Source address is always forced to the station address.
                    ob = emnr_pkg::mac_byte(station_mac, 3'(pos_reg - 11'd6));
                    if (ob != data_byte)
                    begin
                        changed_next = 1'b1;
                    end
                end
                else if (arp && pos_reg >= 11'd22 && pos_reg <= 11'd27)
                begin
                    // ARP sender hardware address.
                    hold_we  = 1'b1;
                    hold_idx = 3'(pos_reg - 11'd22);
                    if (pos_reg == 11'd27)
                    begin
                        rel       = 1'b1;
                        allow     = 1'b1;
                        match_mac = inner_mac;
                        avoid_mac = station_mac;
                        repl_mac  = station_mac;
                    end
                    else
                    begin
                        push.cnt = emnr_pkg::PUSH_NONE;
                    end
                end
                else
                begin
                    if (pos_reg == 11'd14)
                    begin
                        udp_next = 7'd0;
                        if (etype_next == emnr_pkg::TYPE_IPV4 &&
                            len_next >= 11'(emnr_pkg::IP_MIN_LEN) &&
                            data_byte[7:4] == 4'd4 && ihl >= 6'd20 &&
                            {1'b0, len_next} >= hdr_end)
                        begin
                            udp_next = udp_val;
                        end
                    end
                    else if (pos_reg == 11'd20)
                    begin
                        if ((data_byte & emnr_pkg::FRAG_HI_MASK) != 8'h00)
                        begin
                            udp_next = 7'd0;
                        end
                    end
                    else if (pos_reg == 11'd21)
                    begin
                        if (data_byte != 8'h00)
                        begin
                            udp_next = 7'd0;
                        end
                    end
                    else if (pos_reg == 11'd23)
                    begin
                        if (data_byte != emnr_pkg::PROTO_UDP)
                        begin
                            udp_next = 7'd0;
                        end
                    end

                    if (udp_next != 7'd0 && pos_reg >= {4'b0, udp_next})
                    begin
                        off     = pos_reg - {4'b0, udp_next};
                        udp_end = {5'b0, udp_next} + 12'd20;
                        if (off < 11'd4)
                        begin
                            ports_next = {ports_next[23:0], data_byte};
                            if (off == 11'd3 && ports_next == emnr_pkg::DHCP_PORTS &&
                                {1'b0, len_next} >= udp_end)
                            begin
                                dhcp_next = 1'b1;
                            end
                        end
                        if (dhcp_next)
                        begin
                            if (off == 11'd6 || off == 11'd7)
                            begin
                                // UDP checksum is cleared.
                                ob = 8'h00;
                                if (data_byte != 8'h00)
                                begin
                                    changed_next = 1'b1;
                                end
                            end
                            else if (off == 11'd18)
                            begin
                                // BOOTP broadcast flag.
                                ob = data_byte | emnr_pkg::BCAST_BIT;
                                if (!data_byte[7])
                                begin
                                    changed_next = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            else
            begin
                if (pos_reg <= 11'd5)
                begin
                    // Destination address; group addresses are left alone.
                    hold_we  = 1'b1;
                    hold_idx = pos_reg[2:0];
                    if (pos_reg == 11'd5)
                    begin
                        rel       = 1'b1;
                        allow     = !hold_reg[0][0];
                        match_mac = station_mac;
                        avoid_mac = inner_mac;
                        repl_mac  = inner_mac;
                    end
                    else
                    begin
                        push.cnt = emnr_pkg::PUSH_NONE;
                    end
                end
                else if (arp && pos_reg >= 11'd32 && pos_reg <= 11'd37)
                begin
                    // ARP target hardware address.
                    hold_we  = 1'b1;
                    hold_idx = 3'(pos_reg - 11'd32);
                    if (pos_reg == 11'd37)
                    begin
                        rel       = 1'b1;
                        allow     = 1'b1;
                        match_mac = station_mac;
                        avoid_mac = inner_mac;
                        repl_mac  = inner_mac;
                    end
                    else
                    begin
                        push.cnt = emnr_pkg::PUSH_NONE;
                    end
                end
            end
        end

        swap = rel && allow && (cand == match_mac) && (cand != avoid_mac);
        if (swap)
        begin
            changed_next = 1'b1;
        end

        if (rel)
        begin
            push.cnt = emnr_pkg::PUSH_FIELD;
            for (int i = 0; i < 6; i++)
            begin
                push.data[i] = swap ? emnr_pkg::mac_byte(repl_mac, 3'(i))
                                    : emnr_pkg::mac_byte(cand, 3'(i));
            end
        end
        else
        begin
            push.data[0] = ob;
        end
        push.last    = last;
        push.changed = changed_next;

        pos_next = last ? 11'd0 : (pos_reg + 11'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= 11'd0;
            len_reg     <= 11'd0;
            dir_reg     <= 1'b0;
            etype_reg   <= 16'h0000;
            udp_reg     <= 7'd0;
            dhcp_reg    <= 1'b0;
            ports_reg   <= 32'h0;
            changed_reg <= 1'b0;
        end
        else if (fire)
        begin
            pos_reg     <= pos_next;
            len_reg     <= len_next;
            dir_reg     <= dir_next;
            etype_reg   <= etype_next;
            udp_reg     <= udp_next;
            dhcp_reg    <= dhcp_next;
            ports_reg   <= ports_next;
            changed_reg <= changed_next;
        end
    end

    // The sixth byte of a field is never stored; it is used straight from the input.
    always_ff @(posedge clk)
    begin
        if (fire && hold_we && hold_idx < 3'd5)
        begin
            hold_reg[hold_idx] <= data_byte;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/emnr_outq.sv */
`default_nettype none

module emnr_outq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_en,
    input  emnr_pkg::push_t push,
    output logic            room,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_byte,
    output logic            out_last,
    output logic            out_changed
);

    localparam int unsigned DEPTH = emnr_pkg::OUTQ_DEPTH;
    localparam int unsigned AW    = emnr_pkg::OUTQ_AW;
    localparam logic [AW:0] ROOM_LIMIT = (AW + 1)'(DEPTH - emnr_pkg::RELEASE_LEN);

    logic [7:0]    byte_reg [DEPTH];
    logic          last_reg [DEPTH];
    logic          chg_reg  [DEPTH];
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [AW:0]   count_reg, count_next;

    logic [AW-1:0] slot_ofs [DEPTH];
    logic          slot_we  [DEPTH];
    logic          slot_end [DEPTH];
    logic          pop;
    logic [AW:0]   push_cnt;

    assign room        = (count_reg <= ROOM_LIMIT);
    assign out_valid   = (count_reg != '0);
    assign out_byte    = byte_reg[head_reg];
    assign out_last    = last_reg[head_reg];
    assign out_changed = chg_reg[head_reg];
    assign pop         = out_valid && out_ready;
    assign push_cnt    = push_en ? (AW + 1)'(push.cnt) : '0;

    always_comb
    begin
        for (int j = 0; j < DEPTH; j++)
        begin
            slot_ofs[j] = AW'(j) - tail_reg;
            slot_we[j]  = push_en && ({1'b0, slot_ofs[j]} < push_cnt);
            slot_end[j] = ({1'b0, slot_ofs[j]} == (push_cnt - (AW + 1)'(1)));
        end
        head_next  = head_reg + (pop ? AW'(1) : AW'(0));
        tail_next  = tail_reg + AW'(push_cnt);
        count_next = count_reg + push_cnt - (pop ? (AW + 1)'(1) : (AW + 1)'(0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < DEPTH; j++)
        begin
            if (slot_we[j])
            begin
                byte_reg[j] <= push.data[slot_ofs[j][2:0]];
                last_reg[j] <= push.last && slot_end[j];
                chg_reg[j]  <= push.changed && push.last && slot_end[j];
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/ethernet_mac_nat_rewriter.sv */
// MAC NAT frame rewriter: Ethernet frames enter one byte per request on the
// s_ channel and leave, rewritten, one byte per request on the m_ channel.
// Each input request carries the byte, the frame length and the direction
// (s_tuser: 0 egress, 1 ingress); length and direction are taken from the
// first byte of a frame. Output requests carry the byte, tlast on the final
// byte and, in tuser alongside tlast, a flag telling whether the frame changed.
// The input register and the output queue lie between input acceptance and the first
// chance of output acceptance. Bytes of an address field that may be replaced are
// held until the field's sixth byte and then leave as a burst of six, one per cycle
// unless stalled. Throughput is one byte per cycle in both directions while the
// queue has room; the per-byte rewrite is a single registered pass, and a 16-entry
// output queue absorbs the bursts. Reset clears the frame position, the queue and
// both address registers. When the receiver stalls, bytes collect in the queue;
// once more than ten wait, s_tready drops while a byte is held, until no more than
// ten remain. The APB port holds the station MAC at address 0 and the inner MAC at 8.
`default_nettype none

module ethernet_mac_nat_rewriter #(
    parameter int unsigned MAX_FRAME_BYTES = emnr_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] data_byte, [18:8] frame_len, [23:19] zero
    input  logic        s_tuser,   // [0] mode

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,
    output logic        m_tuser,   // [0] frame_changed

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [47:0] station_reg;
    logic [47:0] inner_reg;
    logic        cfg_wr;
    emnr_pkg::reg_sel_t reg_sel;

    // Input register: one accepted byte waiting for its rewrite pass.
    logic        in_valid_reg;
    logic        in_mode_reg;
    logic [7:0]  in_byte_reg;
    logic [10:0] in_len_reg;

    logic            fire;
    logic            room;
    emnr_pkg::push_t push;

    assign pready  = 1'b1;
    assign reg_sel = emnr_pkg::reg_sel_t'(paddr[3]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb
    begin
        case (reg_sel)
            emnr_pkg::REG_STATION: prdata = {16'h0000, station_reg};
            emnr_pkg::REG_INNER:   prdata = {16'h0000, inner_reg};
            default:               prdata = 64'h0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            station_reg <= 48'h0;
            inner_reg   <= 48'h0;
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                emnr_pkg::REG_STATION: station_reg <= pwdata[47:0];
                emnr_pkg::REG_INNER:   inner_reg   <= pwdata[47:0];
                default:               station_reg <= station_reg;
            endcase
        end
    end

    // The held byte goes through the rewrite pass whenever the queue has room
    // for a full burst, so a new request can be taken in the same cycle.
    assign fire     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_mode_reg <= s_tuser;
            in_byte_reg <= s_tdata[7:0];
            in_len_reg  <= s_tdata[18:8];
        end
    end

    emnr_rewrite #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_rewrite (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .mode       (in_mode_reg),
        .data_byte  (in_byte_reg),
        .frame_len  (in_len_reg),
        .station_mac(station_reg),
        .inner_mac  (inner_reg),
        .push       (push)
    );

    emnr_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_en    (fire),
        .push       (push),
        .room       (room),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (m_tdata),
        .out_last   (m_tlast),
        .out_changed(m_tuser)
    );

endmodule

`default_nettype wire

/* hw/rtl/emnr_checker.sv */
`default_nettype none

module emnr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata,
    input wire logic        m_tlast,
    input wire logic        m_tuser,
    input wire logic        psel,
    input wire logic        penable,
    input wire logic        pwrite,
    input wire logic [3:0]  paddr,
    input wire logic [63:0] pwdata,
    input wire logic [63:0] prdata,
    input wire logic        pready
);

    // A stalled output request keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) &&
                                  $stable(m_tuser))
        else $error("output request changed while stalled");

    // The changed flag is only reported on the final byte of a frame.
    a_changed_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame changed flag without tlast");

    // A station address write reads back on the next cycle.
    a_station_rdback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && !paddr[3])
        ##1 (!paddr[3] && !(psel && penable && pwrite))
        |-> prdata[47:0] == $past(pwdata[47:0]))
        else $error("station address readback mismatch");

    // An inner address write reads back on the next cycle.
    a_inner_rdback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && paddr[3])
        ##1 (paddr[3] && !(psel && penable && pwrite))
        |-> prdata[47:0] == $past(pwdata[47:0]))
        else $error("inner address readback mismatch");

endmodule

bind ethernet_mac_nat_rewriter emnr_checker u_emnr_checker (.*);

`default_nettype wire
